FILE: src/vag_pkg.sv
`timescale 1ns / 1ps

package vag_pkg;

   localparam int FRAME_BYTES = 16;
   localparam int POS_W       = $clog2(FRAME_BYTES);
   localparam int BYTE_W      = 8;
   localparam int NIB_W       = 4;
   localparam int SHIFT_W     = 4;
   localparam int PRED_COUNT  = 5;
   localparam int PRED_W      = $clog2(PRED_COUNT);
   localparam int COEF_W      = 8;
   localparam int HIST_W      = 22;
   localparam int PCM_W       = 16;
   localparam int RAW_W       = 16;
   localparam int FRAC_W      = 6;

   localparam logic [POS_W-1:0]  POS_HEADER = POS_W'(0);
   localparam logic [POS_W-1:0]  POS_FLAGS  = POS_W'(1);
   localparam logic [BYTE_W-1:0] FLAG_STOP  = BYTE_W'(7);

   // one data byte waiting for decode, with the header it belongs to
   typedef struct packed {
      logic                valid;
      logic [BYTE_W-1:0]   data;
      logic [PRED_W-1:0]   pred;
      logic [SHIFT_W-1:0]  shift;
   } slot_type;

   typedef struct packed {
      logic signed [PCM_W-1:0] pcm;
      logic                    last;
   } sample_type;

   typedef struct packed {
      logic slot_valid;
      logic phase;
   } dec_stat_type;

   function automatic logic signed [COEF_W-1:0] coef_one(input logic [PRED_W-1:0] p);
      logic signed [COEF_W-1:0] c;
      case (p)
         PRED_W'(1): c = COEF_W'(60);
         PRED_W'(2): c = COEF_W'(115);
         PRED_W'(3): c = COEF_W'(98);
         PRED_W'(4): c = COEF_W'(122);
         default:    c = '0;
      endcase
      return c;
   endfunction

   function automatic logic signed [COEF_W-1:0] coef_two(input logic [PRED_W-1:0] p);
      logic signed [COEF_W-1:0] c;
      case (p)
         PRED_W'(2): c = -COEF_W'(52);
         PRED_W'(3): c = -COEF_W'(55);
         PRED_W'(4): c = -COEF_W'(60);
         default:    c = '0;
      endcase
      return c;
   endfunction

endpackage

FILE: src/vag_frame_parse.sv
`timescale 1ns / 1ps

module vag_frame_parse (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_accept,
   input  logic [vag_pkg::BYTE_W-1:0]  in_data,
   input  logic                        in_start,
   output vag_pkg::slot_type           push,
   output logic                        stopped
);
   import vag_pkg::*;

   logic [POS_W-1:0]   pos_ff, pos_in, pos_eff, pos_next;
   logic [PRED_W-1:0]  pred_ff, pred_in;
   logic [SHIFT_W-1:0] shift_ff, shift_in;
   logic               stop_ff, stop_in, stop_eff;
   logic [NIB_W-1:0]   hdr_pred;

   assign hdr_pred = in_data[BYTE_W-1:NIB_W];

   always_comb begin
      pos_eff  = in_start ? POS_HEADER : pos_ff;
      stop_eff = in_start ? 1'b0 : stop_ff;
      pos_next = (pos_eff == POS_W'(FRAME_BYTES - 1)) ? POS_HEADER : pos_eff + POS_W'(1);
      pos_in   = pos_ff;
      stop_in  = stop_ff;
      pred_in  = pred_ff;
      shift_in = shift_ff;
      if (in_accept) begin
         pos_in  = pos_eff;
         stop_in = stop_eff;
         if (!stop_eff) begin
            if (pos_eff == POS_HEADER) begin
               // unknown predictors fall back to no prediction
               pred_in  = (hdr_pred > NIB_W'(PRED_COUNT - 1)) ? '0 : hdr_pred[PRED_W-1:0];
               shift_in = in_data[SHIFT_W-1:0];
               pos_in   = pos_next;
            end else if (pos_eff == POS_FLAGS) begin
               if (in_data == FLAG_STOP) begin
                  stop_in = 1'b1;
               end else begin
                  pos_in = pos_next;
               end
            end else begin
               pos_in = pos_next;
            end
         end
      end
   end

   always_comb begin
      push.valid = in_accept && !stop_eff && (pos_eff != POS_HEADER) && (pos_eff != POS_FLAGS);
      push.data  = in_data;
      push.pred  = pred_ff;
      push.shift = shift_ff;
   end

   assign stopped = stop_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         pred_ff  <= '0;
         shift_ff <= '0;
         stop_ff  <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         pred_ff  <= pred_in;
         shift_ff <= shift_in;
         stop_ff  <= stop_in;
      end
   end

endmodule

FILE: src/vag_nibble_dec.sv
`timescale 1ns / 1ps

module vag_nibble_dec (
   input  logic                  clock,
   input  logic                  reset,
   input  vag_pkg::slot_type     push,
   output logic                  slot_ready,
   input  logic                  out_ready,
   output logic                  out_valid,
   output vag_pkg::sample_type   out_sample,
   output vag_pkg::dec_stat_type stat
);
   import vag_pkg::*;

   localparam int PROD_W = HIST_W + COEF_W;
   localparam int ACC_W  = PROD_W + 1;
   localparam int PRD_W  = ACC_W - FRAC_W;
   localparam int NEXT_W = PRD_W + 1;
   localparam int RND_W  = HIST_W + 1;
   localparam int PCMW_W = RND_W - FRAC_W;

   localparam logic signed [NEXT_W-1:0] NEXT_HI = NEXT_W'((2 ** (HIST_W - 1)) - 1);
   localparam logic signed [NEXT_W-1:0] NEXT_LO = -NEXT_HI - NEXT_W'(1);
   localparam logic signed [PCMW_W-1:0] PCM_HI  = PCMW_W'((2 ** (PCM_W - 1)) - 1);
   localparam logic signed [PCMW_W-1:0] PCM_LO  = -PCM_HI - PCMW_W'(1);
   localparam logic signed [ACC_W-1:0]  ACC_HALF = ACC_W'(2 ** (FRAC_W - 1));
   localparam logic signed [RND_W-1:0]  RND_HALF = RND_W'(2 ** (FRAC_W - 1));

   slot_type                 slot_ff, slot_in;
   logic                     phase_ff, phase_in;
   logic signed [HIST_W-1:0] h1_ff, h1_in, h2_ff, h2_in;
   logic                     fire;

   logic [NIB_W-1:0]         nib;
   logic signed [RAW_W-1:0]  raw;
   logic signed [COEF_W-1:0] c1, c2;
   logic signed [PROD_W-1:0] prod_one, prod_two;
   logic signed [ACC_W-1:0]  acc;
   logic signed [PRD_W-1:0]  pred_val;
   logic signed [NEXT_W-1:0] next_wide;
   logic signed [HIST_W-1:0] next_hist;
   logic signed [RND_W-1:0]  rnd;
   logic signed [PCMW_W-1:0] pcm_wide;
   logic signed [PCM_W-1:0]  pcm;

   assign fire       = slot_ff.valid && out_ready;
   assign slot_ready = !slot_ff.valid || (fire && phase_ff);

   always_comb begin
      nib      = phase_ff ? slot_ff.data[BYTE_W-1:NIB_W] : slot_ff.data[NIB_W-1:0];
      raw      = $signed({nib, {(RAW_W - NIB_W){1'b0}}}) >>> slot_ff.shift;
      c1       = coef_one(slot_ff.pred);
      c2       = coef_two(slot_ff.pred);
      prod_one = PROD_W'(h1_ff) * PROD_W'(c1);
      prod_two = PROD_W'(h2_ff) * PROD_W'(c2);
      acc      = ACC_W'(prod_one) + ACC_W'(prod_two) + ACC_HALF;
      pred_val = PRD_W'(acc >>> FRAC_W);
      next_wide = (NEXT_W'(raw) <<< FRAC_W) + NEXT_W'(pred_val);
      if (next_wide > NEXT_HI) begin
         next_hist = HIST_W'(NEXT_HI);
      end else if (next_wide < NEXT_LO) begin
         next_hist = HIST_W'(NEXT_LO);
      end else begin
         next_hist = HIST_W'(next_wide);
      end
      rnd      = RND_W'(next_hist) + RND_HALF;
      pcm_wide = PCMW_W'(rnd >>> FRAC_W);
      if (pcm_wide > PCM_HI) begin
         pcm = PCM_W'(PCM_HI);
      end else if (pcm_wide < PCM_LO) begin
         pcm = PCM_W'(PCM_LO);
      end else begin
         pcm = PCM_W'(pcm_wide);
      end
   end

   always_comb begin
      slot_in  = slot_ff;
      phase_in = phase_ff;
      h1_in    = h1_ff;
      h2_in    = h2_ff;
      if (fire) begin
         h2_in    = h1_ff;
         h1_in    = next_hist;
         phase_in = !phase_ff;
         if (phase_ff) begin
            slot_in.valid = 1'b0;
         end
      end
      // load the next byte as the high-nibble sample leaves
      if (push.valid) begin
         slot_in  = push;
         phase_in = 1'b0;
      end
   end

   assign out_valid       = fire;
   assign out_sample.pcm  = pcm;
   assign out_sample.last = phase_ff;
   assign stat.slot_valid = slot_ff.valid;
   assign stat.phase      = phase_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff  <= '0;
         phase_ff <= 1'b0;
         h1_ff    <= '0;
         h2_ff    <= '0;
      end else begin
         slot_ff  <= slot_in;
         phase_ff <= phase_in;
         h1_ff    <= h1_in;
         h2_ff    <= h2_in;
      end
   end

endmodule

FILE: src/vag_out_skid.sv
`timescale 1ns / 1ps

module vag_out_skid (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  vag_pkg::sample_type in_sample,
   output logic                in_ready,
   output logic                out_valid,
   output vag_pkg::sample_type out_sample,
   input  logic                out_ready
);
   import vag_pkg::*;

   sample_type main_ff, main_in, skid_ff, skid_in;
   logic       main_valid_ff, main_valid_in, skid_valid_ff, skid_valid_in;

   assign in_ready   = !skid_valid_ff;
   assign out_valid  = main_valid_ff;
   assign out_sample = main_ff;

   always_comb begin
      main_in       = main_ff;
      main_valid_in = main_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (!main_valid_ff || out_ready) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            main_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            main_in       = in_sample;
            main_valid_in = in_valid;
         end
      end else if (in_valid) begin
         // park the transaction while the output is stalled
         skid_in       = in_sample;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

FILE: src/vag_adpcm_decoder.sv
`timescale 1ns / 1ps
// channel   dir  tdata                     tuser / tlast
// req_*     in   [7:0] data_byte           tuser: start_of_stream
// rsp_*     out  [15:0] pcm_sample (signed) tlast: last_of_byte
//
// Header and flags bytes give no sample. Each data byte gives two samples,
// one per cycle while the output stage takes them; the next byte is taken
// as its high-nibble sample leaves. The limit is the history recurrence,
// one sample a cycle. A byte waits in the decode slot register while its
// low-nibble and then its high-nibble sample pass to the output register.
// Reset clears the history, frame position, header and stop state.
// A stalled output holds two samples in the output stage before the input stalls.

module vag_adpcm_decoder (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [7:0]                 req_tdata,   // [7:0] data_byte
   input  logic                       req_tuser,   // [0] start_of_stream
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [15:0]                rsp_tdata,   // [15:0] pcm_sample
   output logic                       rsp_tlast
);
   import vag_pkg::*;

   slot_type     push;
   logic         stopped;
   logic         req_accept;
   logic         dec_valid, skid_ready;
   sample_type   dec_sample, rsp_sample;
   dec_stat_type dec_stat;

   assign req_accept = req_tvalid && req_tready;

   vag_frame_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .in_accept (req_accept),
      .in_data   (req_tdata),
      .in_start  (req_tuser),
      .push      (push),
      .stopped   (stopped)
   );

   vag_nibble_dec u_dec (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .slot_ready (req_tready),
      .out_ready  (skid_ready),
      .out_valid  (dec_valid),
      .out_sample (dec_sample),
      .stat       (dec_stat)
   );

   vag_out_skid u_skid (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (dec_valid),
      .in_sample  (dec_sample),
      .in_ready   (skid_ready),
      .out_valid  (rsp_tvalid),
      .out_sample (rsp_sample),
      .out_ready  (rsp_tready)
   );

   assign rsp_tdata = rsp_sample.pcm;
   assign rsp_tlast = rsp_sample.last;

   a_phase_has_slot: assert property (@(posedge clock) disable iff (reset)
      dec_stat.phase |-> dec_stat.slot_valid)
      else $error("high-nibble phase without a loaded byte");

   a_no_accept_mid_byte: assert property (@(posedge clock) disable iff (reset)
      (req_accept && dec_stat.slot_valid) |-> dec_stat.phase)
      else $error("transaction accepted while a low-nibble sample is pending");

   a_stopped_no_push: assert property (@(posedge clock) disable iff (reset)
      (req_accept && stopped && !req_tuser) |-> !push.valid)
      else $error("data byte decoded while stopped");

   a_low_then_high: assert property (@(posedge clock) disable iff (reset)
      (dec_valid && !dec_sample.last) |=> dec_stat.phase)
      else $error("low-nibble sample not followed by high-nibble phase");

endmodule

FILE: verif/vag_adpcm_decoder_tb.sv
`timescale 1ns / 1ps

module vag_adpcm_decoder_tb;

   import vag_pkg::*;

   localparam int     STALL_LIMIT  = 3000;
   localparam int     PHASE_BYTES  = 375;
   localparam int     HOLD_CYCLES  = 400;
   localparam longint HIST_TOP     = (longint'(1) << (HIST_W - 1)) - 1;
   localparam longint HIST_BOT     = -(longint'(1) << (HIST_W - 1));
   localparam longint PCM_TOP      = (longint'(1) << (PCM_W - 1)) - 1;
   localparam longint PCM_BOT      = -(longint'(1) << (PCM_W - 1));

   class sample_scoreboard;
      sample_type               expected_samples[$];
      int                       errors;
      logic signed [HIST_W-1:0] hist_one;
      logic signed [HIST_W-1:0] hist_two;
      logic [POS_W-1:0]         frame_pos;
      logic [PRED_W-1:0]        pred_sel;
      logic [SHIFT_W-1:0]       shift_amt;
      bit                       halted;
      int                       tap_one[PRED_COUNT] = '{0, 60, 115, 98, 122};
      int                       tap_two[PRED_COUNT] = '{0, 0, -52, -55, -60};

      function new();
         errors    = 0;
         hist_one  = '0;
         hist_two  = '0;
         frame_pos = POS_HEADER;
         pred_sel  = '0;
         shift_amt = '0;
         halted    = 1'b0;
      endfunction

      task report(input string msg);
         $display("%t mismatch: %s", $realtime, msg);
         errors++;
      endtask

      // one ADPCM step: scaled nibble plus two-tap prediction, all in Q6
      function logic signed [PCM_W-1:0] decode_nibble(input logic [NIB_W-1:0] nib);
         logic signed [RAW_W-1:0] raw;
         longint                  acc;
         longint                  nxt;
         longint                  pcm;
         raw = $signed({nib, {(RAW_W - NIB_W){1'b0}}}) >>> shift_amt;
         acc = longint'(hist_one) * tap_one[pred_sel] + longint'(hist_two) * tap_two[pred_sel];
         nxt = longint'(raw) * 64 + ((acc + 32) >>> FRAC_W);
         if (nxt > HIST_TOP) nxt = HIST_TOP;
         if (nxt < HIST_BOT) nxt = HIST_BOT;
         hist_two = hist_one;
         hist_one = nxt[HIST_W-1:0];
         pcm = (nxt + 32) >>> FRAC_W;
         if (pcm > PCM_TOP) pcm = PCM_TOP;
         if (pcm < PCM_BOT) pcm = PCM_BOT;
         return pcm[PCM_W-1:0];
      endfunction

      function void note_byte(input logic [BYTE_W-1:0] data, input logic start);
         sample_type s;
         if (start) begin
            frame_pos = POS_HEADER;
            halted    = 1'b0;
         end
         if (halted) return;
         if (frame_pos == POS_HEADER) begin
            // out-of-range predictor falls back to the flat one
            pred_sel  = (data[7:4] >= PRED_COUNT) ? '0 : PRED_W'(data[7:4]);
            shift_amt = data[3:0];
         end else if (frame_pos == POS_FLAGS) begin
            if (data == FLAG_STOP) halted = 1'b1;
         end else begin
            s.pcm  = decode_nibble(data[3:0]);
            s.last = 1'b0;
            expected_samples.push_back(s);
            s.pcm  = decode_nibble(data[7:4]);
            s.last = 1'b1;
            expected_samples.push_back(s);
         end
         // frame length is a power of two, so the position wraps by itself
         if (!halted) frame_pos = frame_pos + 1'b1;
      endfunction

      task check_sample(input logic signed [PCM_W-1:0] pcm, input logic last);
         sample_type want;
         if (expected_samples.size() == 0) begin
            report($sformatf("unexpected sample %0d last %0b", pcm, last));
            return;
         end
         want = expected_samples.pop_front();
         if (pcm !== want.pcm)
            report($sformatf("pcm_sample got %0d want %0d", pcm, want.pcm));
         if (last !== want.last)
            report($sformatf("last_of_byte got %0b want %0b", last, want.last));
      endtask
   endclass

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [7:0]        req_tdata  = '0;   // [7:0] data_byte
   logic              req_tuser  = 1'b0; // [0] start_of_stream
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [15:0]       rsp_tdata;         // [15:0] pcm_sample
   logic              rsp_tlast;         // last_of_byte

   sample_scoreboard  sb = new();
   int                send_idle_pct = 0;
   int                recv_idle_pct = 0;
   int                hold_requests = 0;
   int                hold_seen     = 0;
   int                hold_left     = 0;
   int                stall_cycles  = 0;
   int                item_count    = 0;
   bit                aligned       = 1'b0;

   vag_adpcm_decoder DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #2 clock = ~clock;

   // result side: check each transaction, then pick tready for the next edge
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_sample($signed(rsp_tdata), rsp_tlast);
      if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (hold_requests != hold_seen) begin
         hold_seen  <= hold_requests;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic send_byte(input logic [BYTE_W-1:0] data, input logic start);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct && gap < 20) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= start;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_byte(data, start);
   endtask

   task automatic wait_for_samples();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.expected_samples.size() != 0) @(posedge clock);
   endtask

   // mostly whole frames with random content; some cut short, stopped or restarted
   task automatic send_frame();
      int                n_bytes;
      int                n_junk;
      logic [BYTE_W-1:0] flags;
      logic [3:0]        pred_nib;
      bit                stray;
      n_bytes  = ($urandom_range(19) == 0) ? $urandom_range(FRAME_BYTES - 1, 1) : FRAME_BYTES;
      pred_nib = ($urandom_range(5) == 0) ? 4'($urandom_range(15, PRED_COUNT))
                                          : 4'($urandom_range(PRED_COUNT - 1));
      send_byte({pred_nib, 4'($urandom_range(15))}, !aligned || ($urandom_range(9) == 0));
      aligned = 1'b1;
      item_count++;
      if (n_bytes == 1) begin
         aligned = 1'b0;
         return;
      end
      flags = BYTE_W'($urandom_range(255));
      if ($urandom_range(11) == 0)
         flags = FLAG_STOP;
      else if (flags == FLAG_STOP)
         flags = '0;
      send_byte(flags, 1'b0);
      item_count++;
      if (flags == FLAG_STOP) begin
         // ignored while stopped, so not counted
         n_junk = $urandom_range(3);
         repeat (n_junk) send_byte(BYTE_W'($urandom_range(255)), 1'b0);
         aligned = 1'b0;
         return;
      end
      for (int i = 2; i < n_bytes; i++) begin
         stray = ($urandom_range(149) == 0);
         send_byte(BYTE_W'($urandom_range(255)), stray);
         item_count++;
         if (stray) aligned = 1'b0;
      end
      if (n_bytes < FRAME_BYTES) aligned = 1'b0;
   endtask

   initial begin
      logic [8:0] directed[$];
      int         target;
      bit         paused;
      // {start_of_stream, data_byte}
      directed = '{9'h140, 9'h000, 9'h077, 9'h077, 9'h077, 9'h077, 9'h088,
                   9'h1DF, {1'b0, FLAG_STOP}, 9'h055, 9'h000,
                   9'h11C, 9'h0FF, 9'h0F0, 9'h00F,
                   9'h12D, 9'h006, 9'h081,
                   9'h13E, 9'h008, 9'h0A5, 9'h05A,
                   9'h100, 9'h000, 9'h180};
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) send_byte(directed[i][7:0], directed[i][8]);
      item_count = directed.size();
      wait_for_samples();

      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 34 : (ph == 1) ? 61 : 0;
         recv_idle_pct = (ph == 0) ? 61 : (ph == 1) ? 34 : 0;
         target = item_count + PHASE_BYTES;
         paused = 1'b0;
         while (item_count < target) begin
            send_frame();
            if (!paused && item_count > target - PHASE_BYTES / 2) begin
               paused = 1'b1;
               // long receiver hold-off while bytes keep coming, or a full drain
               if (ph == 1)
                  wait_for_samples();
               else
                  hold_requests++;
            end
         end
         wait_for_samples();
      end

      repeat (20) @(posedge clock);
      if (sb.errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
